>>> rtl/i8gtm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i8gtm_pkg: shared types and constants of the int8 gemm tile mac
// widths of the packed byte fields and the control structs between units
// ----------------------------------------------------------------------------
package i8gtm_pkg;

   localparam int TILE_COLS   = 16;
   localparam int K_BYTES     = 4;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int PAIR_W      = 64;
   localparam int PAIR_FIELDS = 8;
   localparam int ROW_IDX_W   = 2;
   localparam int ROWS_W      = 3;
   localparam int VALID_W     = 3;
   localparam int PROD_W      = 17;
   localparam int DOT_W       = 19;

   typedef logic [WORD_W-1:0] word_type;

   // accumulator array control
   typedef struct packed {
      logic step;   // add this group into the accumulators
      logic clear;  // last group: clear after the snapshot
   } acc_ctl_type;

   // emit unit control
   typedef struct packed {
      logic              load;  // take a tile snapshot
      logic [ROWS_W-1:0] rows;  // saturated number of rows to send
   } emit_ctl_type;

endpackage
`default_nettype wire

>>> rtl/i8gtm_dot4.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i8gtm_dot4: four-byte dot product, unsigned a by signed b
// result is sign extended to 32 bits
// ----------------------------------------------------------------------------
module i8gtm_dot4 (
   input  wire i8gtm_pkg::word_type a_word,
   input  wire i8gtm_pkg::word_type b_word,
   output i8gtm_pkg::word_type      dot
);

   logic signed [i8gtm_pkg::PROD_W-1:0] prod [i8gtm_pkg::K_BYTES];
   logic signed [i8gtm_pkg::DOT_W-1:0]  sum;

   always_comb begin
      for (int k = 0; k < i8gtm_pkg::K_BYTES; k++) begin
         prod[k] = $signed({1'b0, a_word[k*i8gtm_pkg::BYTE_W +: i8gtm_pkg::BYTE_W]})
                 * $signed(b_word[k*i8gtm_pkg::BYTE_W +: i8gtm_pkg::BYTE_W]);
      end
      sum = i8gtm_pkg::DOT_W'(prod[0]) + i8gtm_pkg::DOT_W'(prod[1])
          + i8gtm_pkg::DOT_W'(prod[2]) + i8gtm_pkg::DOT_W'(prod[3]);
   end

   assign dot = i8gtm_pkg::WORD_W'(sum);

endmodule
`default_nettype wire

>>> rtl/i8gtm_acc_array.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i8gtm_acc_array: rows by 16 int32 accumulators with one dot4 lane each
// exposes accumulator plus current group for the tile snapshot
// ----------------------------------------------------------------------------
module i8gtm_acc_array #(
   parameter int ROWS = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire i8gtm_pkg::acc_ctl_type ctl,
   input  wire i8gtm_pkg::word_type a_words [ROWS],
   input  wire i8gtm_pkg::word_type b_words [i8gtm_pkg::TILE_COLS],
   output i8gtm_pkg::word_type      sums    [ROWS][i8gtm_pkg::TILE_COLS]
);

   i8gtm_pkg::word_type acc_ff [ROWS][i8gtm_pkg::TILE_COLS];
   i8gtm_pkg::word_type acc_in [ROWS][i8gtm_pkg::TILE_COLS];
   i8gtm_pkg::word_type dot    [ROWS][i8gtm_pkg::TILE_COLS];

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar c = 0; c < i8gtm_pkg::TILE_COLS; c++) begin : g_col
         i8gtm_dot4 u_dot4 (
            .a_word (a_words[r]),
            .b_word (b_words[c]),
            .dot    (dot[r][c])
         );
         // wraps modulo 2^32
         assign sums[r][c] = acc_ff[r][c] + dot[r][c];
      end
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < i8gtm_pkg::TILE_COLS; c++) begin
            acc_in[r][c] = ctl.clear ? '0 : sums[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < i8gtm_pkg::TILE_COLS; c++) begin
               acc_ff[r][c] <= '0;
            end
         end
      end else if (ctl.step) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/i8gtm_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i8gtm_emit: tile snapshot buffer and row sequencer
// sends one row per transaction, rows in increasing order
// ----------------------------------------------------------------------------
module i8gtm_emit #(
   parameter int ROWS = 4
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire i8gtm_pkg::emit_ctl_type ctl,
   input  wire i8gtm_pkg::word_type  snap [ROWS][i8gtm_pkg::TILE_COLS],
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [i8gtm_pkg::ROW_IDX_W-1:0] row_index,
   output i8gtm_pkg::word_type       row_sums [i8gtm_pkg::TILE_COLS],
   output logic                      last_row
);

   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(ROWS + 1);

   i8gtm_pkg::word_type buf_ff [ROWS][i8gtm_pkg::TILE_COLS];
   logic             busy_ff;
   logic [RW-1:0]    row_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             take;

   assign rsp_valid = busy_ff;
   assign take      = busy_ff && rsp_ready;
   assign last_row  = (CNT_W'(row_ff) + CNT_W'(1)) == cnt_ff;
   assign can_load  = !busy_ff || (rsp_ready && last_row);
   assign row_index = i8gtm_pkg::ROW_IDX_W'(row_ff);

   always_comb begin
      for (int c = 0; c < i8gtm_pkg::TILE_COLS; c++) begin
         row_sums[c] = buf_ff[row_ff][c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
         cnt_ff  <= '0;
      end else if (ctl.load) begin
         busy_ff <= ctl.rows != '0;
         row_ff  <= '0;
         cnt_ff  <= CNT_W'(ctl.rows);
      end else if (take) begin
         if (last_row) begin
            busy_ff <= 1'b0;
         end else begin
            row_ff <= row_ff + RW'(1);
         end
      end
   end

   // snapshot payload, no reset
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         buf_ff <= snap;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!busy_ff || (rsp_ready && last_row)))
      else $error("snapshot loaded over a tile still being sent");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CNT_W'(row_ff) < cnt_ff))
      else $error("row counter beyond active row count");

   a_done_drops: assert property (@(posedge clock) disable iff (reset)
      (take && last_row && !ctl.load) |=> !rsp_valid)
      else $error("result still valid after final row");

endmodule
`default_nettype wire

>>> rtl/int8_gemm_tile_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int8_gemm_tile_mac: u8 x s8 dot-product accumulator for a 4x16 int32 tile
// input register, 64 parallel dot4 lanes with accumulators, emit buffer
// ----------------------------------------------------------------------------
// Each req transaction carries one k-group (four A bytes per row, four signed
// B bytes per column) and is taken into an input register; from there all
// TILE_ROWS x 16 accumulators add their four-byte dot products in parallel,
// wrapping modulo 2^32. A bytes at and above valid_bytes are zeroed, with
// valid_bytes saturating at four. A new k-group is accepted every cycle
// unless a last group is held. On the last group the sums are copied to
// an emit buffer and the accumulators clear in the same cycle; the buffer
// then sends one rsp transaction per active row, one per cycle while
// rsp_ready is high, starting the cycle after. A last group waits in the
// input register only while the buffer still holds rows of the previous
// tile. csr writes active_rows (reset 4, saturating at TILE_ROWS, zero sends
// nothing); write it only while idle. Accumulators clear directly on reset.
// ----------------------------------------------------------------------------
module int8_gemm_tile_mac #(
   parameter int TILE_ROWS = 4
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_active_rows,
   // k-group input
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [63:0] req_a_rows_lo,
   input  wire  [63:0] req_a_rows_hi,
   input  wire  [63:0] req_b_cols_0_1,
   input  wire  [63:0] req_b_cols_2_3,
   input  wire  [63:0] req_b_cols_4_5,
   input  wire  [63:0] req_b_cols_6_7,
   input  wire  [63:0] req_b_cols_8_9,
   input  wire  [63:0] req_b_cols_10_11,
   input  wire  [63:0] req_b_cols_12_13,
   input  wire  [63:0] req_b_cols_14_15,
   input  wire  [2:0]  req_valid_bytes,
   input  wire         req_last_group,
   // row results
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_row_index,
   output logic [63:0] rsp_sums_0_1,
   output logic [63:0] rsp_sums_2_3,
   output logic [63:0] rsp_sums_4_5,
   output logic [63:0] rsp_sums_6_7,
   output logic [63:0] rsp_sums_8_9,
   output logic [63:0] rsp_sums_10_11,
   output logic [63:0] rsp_sums_12_13,
   output logic [63:0] rsp_sums_14_15,
   output logic        rsp_last_row
);

   localparam int COLS = i8gtm_pkg::TILE_COLS;
   localparam int WW   = i8gtm_pkg::WORD_W;

   // active rows register
   logic [i8gtm_pkg::ROWS_W-1:0] rows_ff;
   logic [i8gtm_pkg::ROWS_W-1:0] eff_rows;

   // input register
   logic                in_vld_ff;
   logic                in_last_ff;
   i8gtm_pkg::word_type a_ff [TILE_ROWS];
   i8gtm_pkg::word_type b_ff [COLS];
   i8gtm_pkg::word_type a_in [TILE_ROWS];
   i8gtm_pkg::word_type b_in [COLS];

   // unpacked views of the ports
   logic [i8gtm_pkg::PAIR_W-1:0] a_pairs [2];
   logic [i8gtm_pkg::PAIR_W-1:0] b_pairs [i8gtm_pkg::PAIR_FIELDS];
   i8gtm_pkg::word_type          a_mask;

   logic                    advance;
   logic                    can_load;
   i8gtm_pkg::acc_ctl_type  acc_ctl;
   i8gtm_pkg::emit_ctl_type emit_ctl;
   i8gtm_pkg::word_type     snap [TILE_ROWS][COLS];
   i8gtm_pkg::word_type     row_sums [COLS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         rows_ff <= csr_active_rows;
      end
   end

   // rows above the tile height saturate
   assign eff_rows = (rows_ff > i8gtm_pkg::ROWS_W'(TILE_ROWS))
                   ? i8gtm_pkg::ROWS_W'(TILE_ROWS) : rows_ff;

   assign a_pairs[0] = req_a_rows_lo;
   assign a_pairs[1] = req_a_rows_hi;
   assign b_pairs[0] = req_b_cols_0_1;
   assign b_pairs[1] = req_b_cols_2_3;
   assign b_pairs[2] = req_b_cols_4_5;
   assign b_pairs[3] = req_b_cols_6_7;
   assign b_pairs[4] = req_b_cols_8_9;
   assign b_pairs[5] = req_b_cols_10_11;
   assign b_pairs[6] = req_b_cols_12_13;
   assign b_pairs[7] = req_b_cols_14_15;

   // byte k survives when k is below the valid count; counts above four keep all
   always_comb begin
      for (int k = 0; k < i8gtm_pkg::K_BYTES; k++) begin
         a_mask[k*i8gtm_pkg::BYTE_W +: i8gtm_pkg::BYTE_W] =
            {i8gtm_pkg::BYTE_W{req_valid_bytes > i8gtm_pkg::VALID_W'(k)}};
      end
      for (int r = 0; r < TILE_ROWS; r++) begin
         a_in[r] = a_pairs[r/2][(r%2)*WW +: WW] & a_mask;
      end
      for (int c = 0; c < COLS; c++) begin
         b_in[c] = b_pairs[c/2][(c%2)*WW +: WW];
      end
   end

   // a last group holds in the input register until the emit buffer is free
   assign advance   = in_vld_ff && (!in_last_ff || can_load);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         in_last_ff <= req_last_group;
      end
   end

   assign acc_ctl.step  = advance;
   assign acc_ctl.clear = in_last_ff;

   assign emit_ctl.load = advance && in_last_ff;
   assign emit_ctl.rows = eff_rows;

   i8gtm_acc_array #(
      .ROWS (TILE_ROWS)
   ) u_acc_array (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .a_words (a_ff),
      .b_words (b_ff),
      .sums    (snap)
   );

   i8gtm_emit #(
      .ROWS (TILE_ROWS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (emit_ctl),
      .snap      (snap),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .row_index (rsp_row_index),
      .row_sums  (row_sums),
      .last_row  (rsp_last_row)
   );

   // pack column pairs, even column low
   assign rsp_sums_0_1   = {row_sums[1],  row_sums[0]};
   assign rsp_sums_2_3   = {row_sums[3],  row_sums[2]};
   assign rsp_sums_4_5   = {row_sums[5],  row_sums[4]};
   assign rsp_sums_6_7   = {row_sums[7],  row_sums[6]};
   assign rsp_sums_8_9   = {row_sums[9],  row_sums[8]};
   assign rsp_sums_10_11 = {row_sums[11], row_sums[10]};
   assign rsp_sums_12_13 = {row_sums[13], row_sums[12]};
   assign rsp_sums_14_15 = {row_sums[15], row_sums[14]};

endmodule
`default_nettype wire
